FILE: src/shth_pkg.sv
package shth_pkg;

    localparam int FRAC_BITS  = 30;
    localparam int RF_W       = 20;
    localparam int COEF_W     = 32;
    localparam int OFF_W      = 15;
    localparam int SAMPLE_W   = 10;
    localparam int TEMP_W     = 16;
    localparam int RES_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // ln(2) in Q30
    localparam logic [29:0] LN2_Q30 = 30'd744261118;

    localparam int KELVIN_CENTI = 27315;

    // 100 * 2^40
    localparam logic [47:0] CENTI_Q40 = 48'd100 << 40;

    localparam logic [RF_W-1:0]   RF_RESET   = 20'd9900;
    localparam logic [COEF_W-1:0] COEF_A_RST = 32'd1237290300;
    localparam logic [COEF_W-1:0] COEF_B_RST = 32'd258068570;
    localparam logic [COEF_W-1:0] COEF_C_RST = 32'd96399;
    localparam logic [OFF_W-1:0]  OFF_RESET  = 15'h7E70;

    localparam logic signed [TEMP_W-1:0] TEMP_MAX = 16'sh7FFF;
    localparam logic signed [TEMP_W-1:0] TEMP_MIN = -16'sh8000;

    typedef enum logic [1:0] {
        FAULT_NONE  = 2'd0,
        FAULT_OPEN  = 2'd1,
        FAULT_SHORT = 2'd2
    } t_fault;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RF     = 3'd0,
        CFG_COEF_A = 3'd1,
        CFG_COEF_B = 3'd2,
        CFG_COEF_C = 3'd3,
        CFG_OFFSET = 3'd4
    } t_cfg_idx;

endpackage

FILE: src/shth_div.sv
module shth_div #(
    parameter int NW = 32,
    parameter int DW = 10,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_sb,
    output logic          o_valid,
    output logic [NW-1:0] o_quo,
    output logic [SW-1:0] o_sb
);

    // one quotient bit per stage, restoring
    logic          r_v  [0:NW-1];
    logic [DW-1:0] r_r  [0:NW-1];
    logic [NW-1:0] r_q  [0:NW-1];
    logic [DW-1:0] r_d  [0:NW-1];
    logic [SW-1:0] r_sb [0:NW-1];

    for (genvar k = 0; k < NW; k++) begin : g_st
        logic          pv;
        logic [DW-1:0] pr;
        logic [NW-1:0] pq;
        logic [DW-1:0] pd;
        logic [SW-1:0] psb;
        logic [DW:0]   rs;
        logic [DW:0]   df;

        if (k == 0) begin : g_in
            assign pv  = i_valid;
            assign pr  = '0;
            assign pq  = i_num;
            assign pd  = i_den;
            assign psb = i_sb;
        end else begin : g_pr
            assign pv  = r_v[k-1];
            assign pr  = r_r[k-1];
            assign pq  = r_q[k-1];
            assign pd  = r_d[k-1];
            assign psb = r_sb[k-1];
        end

        assign rs = {pr, pq[NW-1]};
        assign df = rs - {1'b0, pd};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= pv;
            end
            r_d[k]  <= pd;
            r_sb[k] <= psb;
            if (!df[DW]) begin
                r_r[k] <= df[DW-1:0];
                r_q[k] <= {pq[NW-2:0], 1'b1};
            end else begin
                r_r[k] <= rs[DW-1:0];
                r_q[k] <= {pq[NW-2:0], 1'b0};
            end
        end
    end

    assign o_valid = r_v[NW-1];
    assign o_quo   = r_q[NW-1];
    assign o_sb    = r_sb[NW-1];

endmodule

FILE: src/shth_log2.sv
module shth_log2 #(
    parameter int XW = 36,
    parameter int SW = 1,
    localparam int EW = $clog2(XW),
    localparam int LW = EW + shth_pkg::FRAC_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [XW-1:0] i_x0,
    input  logic [XW-1:0] i_x1,
    input  logic [SW-1:0] i_sb,
    output logic          o_valid,
    output logic [LW-1:0] o_lg0,
    output logic [LW-1:0] o_lg1,
    output logic [SW-1:0] o_sb
);

    localparam int FB = shth_pkg::FRAC_BITS;
    localparam int MW = FB + 1;

    logic [XW-1:0] x_in  [0:1];
    logic [EW-1:0] n_e0  [0:1];
    logic [MW-1:0] n_m0  [0:1];

    logic          r_v  [0:FB];
    logic [SW-1:0] r_sb [0:FB];
    logic [EW-1:0] r_e  [0:FB][0:1];
    logic [MW-1:0] r_m  [0:FB][0:1];
    logic [FB-1:0] r_f  [0:FB][0:1];

    assign x_in[0] = i_x0;
    assign x_in[1] = i_x1;

    // normalize: exponent from top set bit, mantissa in Q30
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            n_e0[l] = '0;
            for (int i = 0; i < XW; i++) begin
                if (x_in[l][i]) begin
                    n_e0[l] = EW'(i);
                end
            end
            n_m0[l] = MW'({x_in[l], {FB{1'b0}}} >> n_e0[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
        r_sb[0] <= i_sb;
        for (int l = 0; l < 2; l++) begin
            r_e[0][l] <= n_e0[l];
            r_m[0][l] <= n_m0[l];
            r_f[0][l] <= '0;
        end
    end

    // one squaring per stage, one fraction bit per stage
    for (genvar k = 1; k <= FB; k++) begin : g_sq
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= r_v[k-1];
            end
            r_sb[k] <= r_sb[k-1];
        end

        for (genvar l = 0; l < 2; l++) begin : g_ln
            logic [2*MW-1:0] sq;
            logic [MW:0]     t;

            assign sq = r_m[k-1][l] * r_m[k-1][l];
            assign t  = sq[FB+MW:FB];

            always_ff @(posedge i_clk) begin
                r_e[k][l] <= r_e[k-1][l];
                if (t[MW]) begin
                    r_m[k][l] <= t[MW:1];
                    r_f[k][l] <= r_f[k-1][l] | (FB'(1) << (FB - k));
                end else begin
                    r_m[k][l] <= t[MW-1:0];
                    r_f[k][l] <= r_f[k-1][l];
                end
            end
        end
    end

    assign o_valid = r_v[FB];
    assign o_sb    = r_sb[FB];
    assign o_lg0   = {r_e[FB][0], r_f[FB][0]};
    assign o_lg1   = {r_e[FB][1], r_f[FB][1]};

endmodule

FILE: src/shth_mul.sv
module shth_mul #(
    parameter int AW = 32,
    parameter int BW = 32,
    parameter int OW = 32,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [AW-1:0] i_a,
    input  logic [BW-1:0] i_b,
    input  logic [SW-1:0] i_sb,
    output logic          o_valid,
    output logic [OW-1:0] o_p,
    output logic [SW-1:0] o_sb
);

    // (a*b) >> 30 in two stages: partial products of both halves of b, then sum and shift
    localparam int BL = BW / 2;
    localparam int BH = BW - BL;
    localparam int PW = AW + BW;

    logic             r_v1;
    logic [AW+BL-1:0] r_plo;
    logic [AW+BH-1:0] r_phi;
    logic [SW-1:0]    r_sb1;
    logic             r_v2;
    logic [OW-1:0]    r_p;
    logic [SW-1:0]    r_sb2;
    logic [PW-1:0]    n_full;

    assign n_full = (PW'(r_phi) << BL) + PW'(r_plo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
        r_plo <= i_a * i_b[BL-1:0];
        r_phi <= i_a * i_b[BW-1:BL];
        r_sb1 <= i_sb;
        r_p   <= OW'(n_full >> shth_pkg::FRAC_BITS);
        r_sb2 <= r_sb1;
    end

    assign o_valid = r_v2;
    assign o_p     = r_p;
    assign o_sb    = r_sb2;

endmodule

FILE: src/thermistor_steinhart_hart_temp_unit.sv
// Throughput: one word per cycle, every cycle; the two divider pipelines and the 30 log2
// squaring stages set the depth. Reset (synchronous, active low) clears all valid bits
// and loads the register defaults; words in flight are dropped. The result strobe is
// one cycle wide and cannot be held off.
module thermistor_steinhart_hart_temp_unit #(
    parameter int ADC_FULL_SCALE = 1023
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    output logic                                  o_busy,
    input  logic [shth_pkg::SAMPLE_W-1:0]         i_adc_sample,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [shth_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [shth_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    output logic                                  o_strobe,
    output logic signed [shth_pkg::TEMP_W-1:0]    o_temperature_centi,
    output logic [shth_pkg::RES_W-1:0]            o_resistance_ohms,
    output logic [1:0]                            o_fault
);

    localparam int FB    = shth_pkg::FRAC_BITS;
    localparam int SMW   = shth_pkg::SAMPLE_W;
    localparam int FSW   = $clog2(ADC_FULL_SCALE + 1);
    localparam int CW    = (FSW > SMW) ? FSW : SMW;
    localparam int NUMW  = shth_pkg::RF_W + FSW;
    localparam int RNW   = NUMW + 1;
    localparam int RXW   = (RNW > shth_pkg::RES_W) ? RNW : shth_pkg::RES_W + 1;
    localparam int LGW   = $clog2(NUMW) + FB;
    localparam int L2W   = 2 * LGW - FB;
    localparam int L3W   = L2W + LGW - FB;
    localparam int CL3W  = shth_pkg::COEF_W + L3W - FB;
    localparam int BLW   = shth_pkg::COEF_W + LGW - FB;
    localparam int MXW   = (CL3W > BLW) ? CL3W : BLW;
    localparam int SUMW  = MXW + 1;
    localparam int DW    = SUMW + 1;
    localparam int DSW   = SUMW + 2;
    localparam int QNW   = SUMW + 2;
    localparam int QL    = 17;
    localparam int TW    = QL + 2;
    localparam int SB1W  = 2 + NUMW + SMW;
    localparam int SBAW  = 2 + shth_pkg::RES_W;
    localparam int SBNW  = SBAW + 1;
    localparam int SBBW  = SBNW + LGW;
    localparam int SBCW  = SBNW + CL3W;
    localparam int SBDW  = SBAW + 1;
    localparam int LAT   = 1 + RNW + (FB + 1) + 1 + 10 + 1 + 1 + QNW + 1;

    // configuration
    logic [shth_pkg::RF_W-1:0]          r_rf;
    logic [shth_pkg::COEF_W-1:0]        r_ca;
    logic [shth_pkg::COEF_W-1:0]        r_cb;
    logic [shth_pkg::COEF_W-1:0]        r_cc;
    logic signed [shth_pkg::OFF_W-1:0]  r_off;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf  <= shth_pkg::RF_RESET;
            r_ca  <= shth_pkg::COEF_A_RST;
            r_cb  <= shth_pkg::COEF_B_RST;
            r_cc  <= shth_pkg::COEF_C_RST;
            r_off <= shth_pkg::OFF_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                shth_pkg::CFG_RF:     r_rf  <= i_cfg_data[shth_pkg::RF_W-1:0];
                shth_pkg::CFG_COEF_A: r_ca  <= i_cfg_data;
                shth_pkg::CFG_COEF_B: r_cb  <= i_cfg_data;
                shth_pkg::CFG_COEF_C: r_cc  <= i_cfg_data;
                shth_pkg::CFG_OFFSET: r_off <= i_cfg_data[shth_pkg::OFF_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_busy      = 1'b0;

    // front stage: divider numerator and fault code
    logic [CW-1:0]          n_s_ext;
    logic [FSW-1:0]         n_span;
    logic [NUMW-1:0]        n_num;
    shth_pkg::t_fault       n_fault;
    logic                   r_f_v;
    logic [SMW-1:0]         r_f_s;
    logic [NUMW-1:0]        r_f_num;
    shth_pkg::t_fault       r_f_fault;

    always_comb begin
        n_s_ext = CW'(i_adc_sample);
        n_span  = (n_s_ext < CW'(ADC_FULL_SCALE)) ? FSW'(CW'(ADC_FULL_SCALE) - n_s_ext) : '0;
        n_num   = NUMW'(r_rf * n_span);
        if (i_adc_sample == '0) begin
            n_fault = shth_pkg::FAULT_OPEN;
        end else if (n_num == '0) begin
            n_fault = shth_pkg::FAULT_SHORT;
        end else begin
            n_fault = shth_pkg::FAULT_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
        end else begin
            r_f_v <= i_start && !o_busy;
        end
        r_f_s     <= i_adc_sample;
        r_f_num   <= n_num;
        r_f_fault <= n_fault;
    end

    // resistance divider
    logic             rd_v;
    logic [RNW-1:0]   rd_q;
    logic [SB1W-1:0]  rd_sb;

    shth_div #(.NW(RNW), .DW(SMW), .SW(SB1W)) u_res_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_f_v),
        .i_num   (RNW'(r_f_num) + RNW'(r_f_s >> 1)),
        .i_den   (r_f_s),
        .i_sb    ({r_f_fault, r_f_num, r_f_s}),
        .o_valid (rd_v),
        .o_quo   (rd_q),
        .o_sb    (rd_sb)
    );

    logic [1:0]                 rd_fault;
    logic [NUMW-1:0]            rd_num;
    logic [SMW-1:0]             rd_s;
    logic [shth_pkg::RES_W-1:0] n_res;

    assign rd_fault = rd_sb[SB1W-1 -: 2];
    assign rd_num   = rd_sb[SMW +: NUMW];
    assign rd_s     = rd_sb[SMW-1:0];

    always_comb begin
        case (rd_fault)
            shth_pkg::FAULT_OPEN:  n_res = '1;
            shth_pkg::FAULT_SHORT: n_res = '0;
            default: begin
                if (RXW'(rd_q) > RXW'({shth_pkg::RES_W{1'b1}})) begin
                    n_res = '1;
                end else begin
                    n_res = shth_pkg::RES_W'(rd_q);
                end
            end
        endcase
    end

    // log2 of numerator and sample
    logic            lg_v;
    logic [LGW-1:0]  lg_n;
    logic [LGW-1:0]  lg_s;
    logic [SBAW-1:0] lg_sb;

    shth_log2 #(.XW(NUMW), .SW(SBAW)) u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (rd_v),
        .i_x0    (rd_num),
        .i_x1    (NUMW'(rd_s)),
        .i_sb    ({rd_fault, n_res}),
        .o_valid (lg_v),
        .o_lg0   (lg_n),
        .o_lg1   (lg_s),
        .o_sb    (lg_sb)
    );

    // sign and magnitude of log2(R)
    logic            r_d_v;
    logic            r_d_neg;
    logic [LGW-1:0]  r_d_mag;
    logic [SBAW-1:0] r_d_sb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else begin
            r_d_v <= lg_v;
        end
        r_d_neg <= lg_n < lg_s;
        r_d_mag <= (lg_n < lg_s) ? lg_s - lg_n : lg_n - lg_s;
        r_d_sb  <= lg_sb;
    end

    // ln R, ln^2, ln^3, C*ln^3, B*ln
    logic            m1_v, m2_v, m3_v, m4_v, m5_v;
    logic [LGW-1:0]  m1_p;
    logic [L2W-1:0]  m2_p;
    logic [L3W-1:0]  m3_p;
    logic [CL3W-1:0] m4_p;
    logic [BLW-1:0]  m5_p;
    logic [SBNW-1:0] m1_sb;
    logic [SBBW-1:0] m2_sb, m3_sb, m4_sb;
    logic [SBCW-1:0] m5_sb;

    shth_mul #(.AW(LGW), .BW(FB), .OW(LGW), .SW(SBNW)) u_mul_ln (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (r_d_v),
        .i_a (r_d_mag), .i_b (shth_pkg::LN2_Q30), .i_sb ({r_d_sb, r_d_neg}),
        .o_valid (m1_v), .o_p (m1_p), .o_sb (m1_sb)
    );

    shth_mul #(.AW(LGW), .BW(LGW), .OW(L2W), .SW(SBBW)) u_mul_sq (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (m1_v),
        .i_a (m1_p), .i_b (m1_p), .i_sb ({m1_sb, m1_p}),
        .o_valid (m2_v), .o_p (m2_p), .o_sb (m2_sb)
    );

    shth_mul #(.AW(L2W), .BW(LGW), .OW(L3W), .SW(SBBW)) u_mul_cube (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (m2_v),
        .i_a (m2_p), .i_b (m2_sb[LGW-1:0]), .i_sb (m2_sb),
        .o_valid (m3_v), .o_p (m3_p), .o_sb (m3_sb)
    );

    shth_mul #(.AW(shth_pkg::COEF_W), .BW(L3W), .OW(CL3W), .SW(SBBW)) u_mul_c (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (m3_v),
        .i_a (r_cc), .i_b (m3_p), .i_sb (m3_sb),
        .o_valid (m4_v), .o_p (m4_p), .o_sb (m4_sb)
    );

    shth_mul #(.AW(shth_pkg::COEF_W), .BW(LGW), .OW(BLW), .SW(SBCW)) u_mul_b (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (m4_v),
        .i_a (r_cb), .i_b (m4_sb[LGW-1:0]), .i_sb ({m4_sb[SBBW-1:LGW], m4_p}),
        .o_valid (m5_v), .o_p (m5_p), .o_sb (m5_sb)
    );

    // denominator D = A +/- (B*ln + C*ln^3), Q40
    logic [SUMW-1:0]        n_sum;
    logic                   m5_neg;
    logic                   r_s_v;
    logic signed [DSW-1:0]  r_s_d;
    logic [SBAW-1:0]        r_s_sb;

    assign n_sum  = SUMW'(m5_p) + SUMW'(m5_sb[CL3W-1:0]);
    assign m5_neg = m5_sb[CL3W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_v <= 1'b0;
        end else begin
            r_s_v <= m5_v;
        end
        r_s_d  <= m5_neg ? $signed(DSW'(r_ca)) - $signed(DSW'(n_sum))
                         : $signed(DSW'(r_ca)) + $signed(DSW'(n_sum));
        r_s_sb <= m5_sb[SBCW-1:CL3W+1];
    end

    // rounded numerator for 100*2^40 / D
    logic            r_n_v;
    logic [QNW-1:0]  r_n_num;
    logic [DW-1:0]   r_n_den;
    logic [SBDW-1:0] r_n_sb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_v <= 1'b0;
        end else begin
            r_n_v <= r_s_v;
        end
        r_n_num <= QNW'(shth_pkg::CENTI_Q40) + QNW'(r_s_d[DW-1:0] >> 1);
        r_n_den <= r_s_d[DW-1:0];
        r_n_sb  <= {r_s_sb, (!r_s_d[DSW-1]) && (r_s_d != '0)};
    end

    logic            td_v;
    logic [QNW-1:0]  td_q;
    logic [SBDW-1:0] td_sb;

    shth_div #(.NW(QNW), .DW(DW), .SW(SBDW)) u_temp_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_n_v),
        .i_num   (r_n_num),
        .i_den   (r_n_den),
        .i_sb    (r_n_sb),
        .o_valid (td_v),
        .o_quo   (td_q),
        .o_sb    (td_sb)
    );

    // output stage
    logic signed [TW-1:0]               n_t;
    logic signed [shth_pkg::TEMP_W-1:0] n_temp;
    logic [1:0]                         td_fault;
    logic                               td_dpos;

    logic                               r_o_v;
    logic signed [shth_pkg::TEMP_W-1:0] r_o_temp;
    logic [shth_pkg::RES_W-1:0]         r_o_res;
    logic [1:0]                         r_o_fault;

    assign td_fault = td_sb[SBDW-1 -: 2];
    assign td_dpos  = td_sb[0];

    always_comb begin
        n_t = $signed({2'b00, td_q[QL-1:0]}) - $signed(TW'(shth_pkg::KELVIN_CENTI))
              + TW'(r_off);
        if (td_fault != shth_pkg::FAULT_NONE) begin
            n_temp = '0;
        end else if (!td_dpos || (td_q[QNW-1:QL] != '0)) begin
            n_temp = shth_pkg::TEMP_MAX;
        end else if (n_t > TW'(shth_pkg::TEMP_MAX)) begin
            n_temp = shth_pkg::TEMP_MAX;
        end else if (n_t < TW'(shth_pkg::TEMP_MIN)) begin
            n_temp = shth_pkg::TEMP_MIN;
        end else begin
            n_temp = shth_pkg::TEMP_W'(n_t);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else begin
            r_o_v <= td_v;
        end
        r_o_temp  <= n_temp;
        r_o_res   <= td_sb[shth_pkg::RES_W:1];
        r_o_fault <= td_fault;
    end

    assign o_strobe            = r_o_v;
    assign o_temperature_centi = r_o_temp;
    assign o_resistance_ohms   = r_o_res;
    assign o_fault             = r_o_fault;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##LAT o_strobe)
        else $error("word lost in pipeline");

    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_start && !o_busy) |-> ##LAT !o_strobe)
        else $error("result without a word");

    a_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_fault == shth_pkg::FAULT_OPEN) |->
        (o_resistance_ohms == '1 && o_temperature_centi == '0))
        else $error("open sensor result wrong");

    a_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_fault == shth_pkg::FAULT_SHORT) |->
        (o_resistance_ohms == '0 && o_temperature_centi == '0))
        else $error("shorted sensor result wrong");

endmodule
